@@ design/sigma_delta_motion_detect_defines.svh @@
// Assertion macros shared by the sigma-delta motion detector RTL.
// Users must have clk_i and rst_ni in scope; no other dependencies.
`ifndef SIGMA_DELTA_MOTION_DETECT_DEFINES_SVH
`define SIGMA_DELTA_MOTION_DETECT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SDMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SDMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sdmd_pkg.sv @@
// Shared types, constants and helper functions for the sigma-delta motion detector.
// No dependencies; the interfaces, top level, front and back end use it by scoped names.
package sdmd_pkg;

  // Frame size in pixels; a power of two, so the index wraps by truncation.
  localparam int unsigned FRAME_PIXELS = 65536;
  localparam int unsigned ADDR_W       = $clog2(FRAME_PIXELS);

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ENTRY_W   = 2 * PIX_W;

  // Decoupling queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register reset values.
  localparam logic [CFG_W-1:0] GAIN_RST        = 8'd2;
  localparam logic [CFG_W-1:0] VAR_FLOOR_RST   = 8'd1;
  localparam logic [CFG_W-1:0] VAR_CEILING_RST = 8'd254;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN        = 2'd0,
    CFG_VAR_FLOOR   = 2'd1,
    CFG_VAR_CEILING = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] gain;
    logic [CFG_W-1:0] var_floor;
    logic [CFG_W-1:0] var_ceiling;
  } cfg_t;

  // One decoded pixel word as it sits in the queue.
  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [ADDR_W-1:0] addr;
    logic              first;
  } item_t;

  // One stored entry: background and variance of a pixel position.
  typedef struct packed {
    logic [PIX_W-1:0] background;
    logic [PIX_W-1:0] variance;
  } entry_t;

  // Move cur one level toward target.
  function automatic logic [PIX_W-1:0] step_toward(input logic [PIX_W-1:0] cur,
                                                   input logic [PIX_W-1:0] target);
    logic [PIX_W-1:0] res;
    res = cur;
    if (cur < target) begin
      res = cur + PIX_W'(1);
    end else if (cur > target) begin
      res = cur - PIX_W'(1);
    end
    return res;
  endfunction

endpackage

@@ design/sdmd_pix_if.sv @@
// Pixel input channel: valid/ready handshake with the pixel word fields.
// Depends on sdmd_pkg for field widths.
interface sdmd_pix_if;
  logic                            valid;
  logic                            ready;
  logic [sdmd_pkg::PIX_W-1:0]      pixel;
  logic [sdmd_pkg::IDX_W-1:0]      pixel_index;
  logic                            first_frame;

  modport source (output valid, output pixel, output pixel_index, output first_frame,
                  input ready);
  modport sink   (input valid, input pixel, input pixel_index, input first_frame,
                  output ready);
endinterface

@@ design/sdmd_res_if.sv @@
// Result output channel: valid/ready handshake with the result word fields.
// Depends on sdmd_pkg for field widths.
interface sdmd_res_if;
  logic                       valid;
  logic                       ready;
  logic [sdmd_pkg::PIX_W-1:0] background;
  logic [sdmd_pkg::PIX_W-1:0] difference;
  logic [sdmd_pkg::PIX_W-1:0] variance;
  logic [sdmd_pkg::PIX_W-1:0] mask;

  modport source (output valid, output background, output difference, output variance,
                  output mask, input ready);
  modport sink   (input valid, input background, input difference, input variance,
                  input mask, output ready);
endinterface

@@ design/sigma_delta_motion_detect.sv @@
// Sigma-delta motion detector top level: one pixel word per cycle while res_o.ready is high,
// one result per word. Each word passes through the queue, the update stage (store read)
// and the output register. The rate is set by the single-port-per-side entry store with
// write-back forwarding for repeated positions. A two-word queue decouples input from output.
// Reset clears the registers (gain 2, floor 1, ceiling 254) and the pipeline; the entry
// store is not cleared, so each position must be initialized with a first-frame word.
`include "sigma_delta_motion_detect_defines.svh"

module sigma_delta_motion_detect (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sdmd_pix_if.sink                       pix_i,
  sdmd_res_if.source                     res_o,
  input  logic                           cfg_we_i,
  input  logic [sdmd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sdmd_pkg::CFG_W-1:0]     cfg_data_i
);

  sdmd_pkg::cfg_t  cfg_q, cfg_d;
  logic            q_valid;
  logic            q_pop;
  sdmd_pkg::item_t q_item;

  // Configuration register writes; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (sdmd_pkg::cfg_idx_e'(cfg_idx_i))
        sdmd_pkg::CFG_GAIN:        cfg_d.gain        = cfg_data_i;
        sdmd_pkg::CFG_VAR_FLOOR:   cfg_d.var_floor   = cfg_data_i;
        sdmd_pkg::CFG_VAR_CEILING: cfg_d.var_ceiling = cfg_data_i;
        default:                   cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain        <= sdmd_pkg::GAIN_RST;
      cfg_q.var_floor   <= sdmd_pkg::VAR_FLOOR_RST;
      cfg_q.var_ceiling <= sdmd_pkg::VAR_CEILING_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: accept and queue.
  sdmd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // Back end: update and present.
  sdmd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

  // The queue never hands out a word while it is empty.
  `SDMD_ASSERT_NOW(a_pop_needs_word, q_pop, q_valid, "queue popped while empty")
  // Registers hold their value when no write is made.
  `SDMD_ASSERT_NEXT(a_cfg_holds, !cfg_we_i, cfg_q == $past(cfg_q), "register changed without a write")
  // An accepted pixel word leaves the queue non-empty on the next cycle.
  `SDMD_ASSERT_NEXT(a_accept_queued, pix_i.valid && pix_i.ready, q_valid, "accepted word not queued")

endmodule

@@ design/sdmd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; contents are undefined after reset. Read during write returns old data.
module sdmd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds when no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/sdmd_front.sv @@
// Front end: accepts pixel words, decodes the store address and queues them.
// Depends on sdmd_pkg and sdmd_pix_if.
module sdmd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  sdmd_pix_if.sink            pix_i,
  output logic                q_valid_o,
  output sdmd_pkg::item_t     q_item_o,
  input  logic                q_pop_i
);

  sdmd_pkg::item_t                   entries_q [sdmd_pkg::QUEUE_DEPTH];
  logic [sdmd_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [sdmd_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [sdmd_pkg::QCNT_W-1:0]       count_q, count_d;
  sdmd_pkg::item_t                   item_in;
  logic                              push;
  logic                              pop;

  // Decode the incoming word; the frame size is a power of two, so the
  // position wraps by keeping the low address bits.
  always_comb begin
    item_in.pixel = pix_i.pixel;
    item_in.addr  = sdmd_pkg::ADDR_W'(pix_i.pixel_index);
    item_in.first = pix_i.first_frame;
  end

  assign pix_i.ready = (count_q != sdmd_pkg::QCNT_W'(sdmd_pkg::QUEUE_DEPTH));
  assign push        = pix_i.valid && pix_i.ready;
  assign pop         = q_pop_i && (count_q != '0);

  assign q_valid_o = (count_q != '0);
  assign q_item_o  = entries_q[rd_ptr_q];

  // Queue pointer and fill-count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + sdmd_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + sdmd_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + sdmd_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - sdmd_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

@@ design/sdmd_back.sv @@
// Back end: reads the stored entry, applies the sigma-delta update, writes it back
// and presents the result. Depends on sdmd_pkg, sdmd_res_if, sdmd_ram and the defines.
`include "sigma_delta_motion_detect_defines.svh"

module sdmd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sdmd_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  sdmd_pkg::item_t     q_item_i,
  output logic                q_pop_o,
  sdmd_res_if.source          res_o
);

  logic                         s2_valid_q, s2_valid_d;
  sdmd_pkg::item_t              s2_q;
  logic                         fwd_q, fwd_d;
  sdmd_pkg::entry_t             fwd_data_q;
  logic                         out_valid_q, out_valid_d;
  logic [sdmd_pkg::PIX_W-1:0]   out_bg_q, out_diff_q, out_var_q, out_mask_q;

  logic                         s2_adv;
  logic                         pop;
  logic [sdmd_pkg::ENTRY_W-1:0] rd_raw;
  sdmd_pkg::entry_t             rd_data;
  sdmd_pkg::entry_t             cur;
  sdmd_pkg::entry_t             new_entry;
  logic [sdmd_pkg::PIX_W-1:0]   bg_step, diff_step, target, var_step, var_hi;
  logic [sdmd_pkg::PIX_W-1:0]   diff_new, mask_new;
  logic [sdmd_pkg::ENTRY_W-1:0] prod;

  // Pipeline flow: the update stage moves when the output register is free
  // or being emptied, and a queued word enters as the stage frees up.
  assign s2_adv  = s2_valid_q && (!out_valid_q || res_o.ready);
  assign pop     = q_valid_i && (!s2_valid_q || s2_adv);
  assign q_pop_o = pop;

  // Entry store: the read is issued as a word enters the update stage,
  // the write-back happens as it leaves.
  sdmd_ram #(
    .WIDTH (sdmd_pkg::ENTRY_W),
    .DEPTH (sdmd_pkg::FRAME_PIXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (s2_adv),
    .waddr_i (s2_q.addr),
    .wdata_i (new_entry),
    .re_i    (pop),
    .raddr_i (q_item_i.addr),
    .rdata_o (rd_raw)
  );

  assign rd_data = rd_raw;

  // Take the forwarded entry when the previous word wrote the same position
  // in the cycle this one was read.
  assign cur = fwd_q ? fwd_data_q : rd_data;

  // Sigma-delta update of background and variance.
  always_comb begin
    bg_step   = sdmd_pkg::step_toward(cur.background, s2_q.pixel);
    diff_step = (bg_step >= s2_q.pixel) ? (bg_step - s2_q.pixel) : (s2_q.pixel - bg_step);
    prod      = sdmd_pkg::ENTRY_W'(cfg_i.gain) * sdmd_pkg::ENTRY_W'(diff_step);
    target    = (|prod[sdmd_pkg::ENTRY_W-1:sdmd_pkg::PIX_W]) ? '1 : prod[sdmd_pkg::PIX_W-1:0];
    var_step  = sdmd_pkg::step_toward(cur.variance, target);
    // Ceiling first, then floor, so the floor wins when the two cross.
    var_hi    = (var_step < cfg_i.var_ceiling) ? var_step : cfg_i.var_ceiling;
    if (s2_q.first) begin
      new_entry.background = s2_q.pixel;
      new_entry.variance   = cfg_i.var_floor;
      diff_new             = '0;
    end else begin
      new_entry.background = bg_step;
      new_entry.variance   = (var_hi < cfg_i.var_floor) ? cfg_i.var_floor : var_hi;
      diff_new             = diff_step;
    end
    mask_new = (diff_new < new_entry.variance) ? cfg_i.var_floor : cfg_i.var_ceiling;
  end

  // Next-state logic for the stage and output valid flags.
  always_comb begin
    s2_valid_d = s2_valid_q;
    fwd_d      = fwd_q;
    if (pop) begin
      s2_valid_d = 1'b1;
      fwd_d      = s2_adv && (q_item_i.addr == s2_q.addr);
    end else if (s2_adv) begin
      s2_valid_d = 1'b0;
      fwd_d      = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s2_adv) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      s2_q       <= q_item_i;
      fwd_data_q <= new_entry;
    end
    if (s2_adv) begin
      out_bg_q   <= new_entry.background;
      out_diff_q <= diff_new;
      out_var_q  <= new_entry.variance;
      out_mask_q <= mask_new;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.background = out_bg_q;
  assign res_o.difference = out_diff_q;
  assign res_o.variance   = out_var_q;
  assign res_o.mask       = out_mask_q;

  // Forwarding only ever applies to a word held in the update stage.
  `SDMD_ASSERT_NOW(a_fwd_needs_stage, fwd_q, s2_valid_q, "forward flag without a word in stage")
  // A stage that drains with nothing behind it must be empty next cycle.
  `SDMD_ASSERT_NEXT(a_stage_drains, s2_adv && !pop, !s2_valid_q, "update stage failed to drain")
  // Every word leaving the update stage shows up at the output.
  `SDMD_ASSERT_NEXT(a_result_lands, s2_adv, out_valid_q, "result lost on the way out")
  // An initializing word always leaves the variance at the floor.
  `SDMD_ASSERT_NOW(a_first_floor, s2_valid_q && s2_q.first,
                   new_entry.variance == cfg_i.var_floor, "first-frame variance not at floor")

endmodule
